### sv/ssb_pkg.sv
// shared types, constants and helpers for the ssb slot position selector
package ssb_pkg;

    localparam int C_SLOT_W      = 17;
    localparam int C_MOD_W       = 11;
    localparam int C_ARFCN_W     = 22;
    localparam int C_CFG_W       = 64;
    localparam int C_CFG_IDX_W   = 3;
    localparam int C_STEPS       = 3;
    localparam int C_MOD_STAGES  = 6;
    localparam int C_WIDE_W      = C_SLOT_W + C_MOD_W;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        REG_PATTERN_CASE   = 3'd0,
        REG_PAIRED         = 3'd1,
        REG_CARRIER_ARFCN  = 3'd2,
        REG_CUTOFF_ABC     = 3'd3,
        REG_CUTOFF_C       = 3'd4,
        REG_BURST_BITMAP   = 3'd5,
        REG_PERIOD_MS      = 3'd6,
        REG_NUMEROLOGY     = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CASE_A = 2'd0,
        CASE_B = 2'd1,
        CASE_C = 2'd2,
        CASE_D = 2'd3
    } t_pattern;

    typedef struct packed {
        logic [1:0]           pattern_case;
        logic                 paired_band;
        logic [C_ARFCN_W-1:0] carrier_arfcn;
        logic [C_ARFCN_W-1:0] cutoff_abc;
        logic [C_ARFCN_W-1:0] cutoff_c_unpaired;
        logic [63:0]          burst_bitmap;
        logic [7:0]           period_ms;
        logic [1:0]           numerology;
    } t_ssb_cfg;

    typedef struct packed {
        logic [1:0] position_count;
        logic [5:0] first_index;
        logic [3:0] first_start;
        logic [3:0] first_stop;
        logic [5:0] second_index;
        logic [3:0] second_start;
        logic [3:0] second_stop;
    } t_ssb_pos;

    // case d slot pairs that carry blocks
    localparam logic [4:0] C_D_PAIRS [16] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd8,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd15, 5'd16, 5'd17, 5'd18
    };

    // returns {hit, position in the pair list}
    function automatic logic [4:0] d_pair_lookup(input logic [4:0] pair);
        logic [4:0] res;
        res = '0;
        for (int k = 0; k < 16; k++) begin
            if (C_D_PAIRS[k] == pair) begin
                res = {1'b1, 4'(k)};
            end
        end
        return res;
    endfunction

endpackage

### sv/ssb_slot_if.sv
// slot number input channel
interface ssb_slot_if;
    import ssb_pkg::*;

    logic                valid;
    logic                ready;
    logic [C_SLOT_W-1:0] slot_number;

    modport source (output valid, output slot_number, input ready);
    modport sink   (input valid, input slot_number, output ready);
endinterface

### sv/ssb_pos_if.sv
// ssb position result channel
interface ssb_pos_if;
    import ssb_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] position_count;
    logic [5:0] first_index;
    logic [3:0] first_start;
    logic [3:0] first_stop;
    logic [5:0] second_index;
    logic [3:0] second_start;
    logic [3:0] second_stop;

    modport source (output valid, output position_count, output first_index,
                    output first_start, output first_stop, output second_index,
                    output second_start, output second_stop, input ready);
    modport sink   (input valid, input position_count, input first_index,
                    input first_start, input first_stop, input second_index,
                    input second_start, input second_stop, output ready);
endinterface

### sv/ssb_mod_stage.sv
// one stage of the restoring slot modulo pipeline
module ssb_mod_stage #(
    parameter int K_HI = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ssb_pkg::C_SLOT_W-1:0] i_rem,
    input  logic [ssb_pkg::C_MOD_W-1:0]  i_modulus,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ssb_pkg::C_SLOT_W-1:0] o_rem
);
    import ssb_pkg::*;

    logic                r_valid;
    logic [C_SLOT_W-1:0] r_rem;
    logic [C_SLOT_W-1:0] n_rem;

    // a zero modulus subtracts nothing, so the slot passes unreduced
    always_comb begin
        logic [C_WIDE_W-1:0] sh;
        n_rem = i_rem;
        for (int j = 0; j < C_STEPS; j++) begin
            sh = C_WIDE_W'(i_modulus) << (K_HI - j);
            if (C_WIDE_W'(n_rem) >= sh) begin
                n_rem = n_rem - sh[C_SLOT_W-1:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem <= n_rem;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
endmodule

### sv/ssb_decode.sv
// candidate position decode and output register
module ssb_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssb_pkg::t_ssb_cfg            i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ssb_pkg::C_SLOT_W-1:0] i_slot,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ssb_pkg::t_ssb_pos            o_pos
);
    import ssb_pkg::*;

    logic     r_valid;
    t_ssb_pos r_pos;
    t_ssb_pos n_pos;

    always_comb begin
        logic                 cand_ok;
        logic [5:0]           idx0;
        logic [3:0]           st0;
        logic [3:0]           st1;
        logic [4:0]           hit;
        logic                 odd;
        logic [C_ARFCN_W-1:0] cutoff;
        logic                 b0;
        logic                 b1;
        n_pos   = '0;
        cand_ok = 1'b0;
        idx0    = '0;
        st0     = 4'd2;
        st1     = 4'd8;
        odd     = i_slot[0];
        hit     = d_pair_lookup(i_slot[5:1]);
        cutoff  = i_cfg.cutoff_abc;
        case (t_pattern'(i_cfg.pattern_case))
            CASE_D: begin
                cand_ok = (i_slot < C_SLOT_W'(40)) && hit[4];
                idx0    = {hit[3:0], odd, 1'b0};
                st0     = odd ? 4'd2 : 4'd4;
                st1     = odd ? 4'd6 : 4'd8;
            end
            CASE_A, CASE_B, CASE_C: begin
                if (i_cfg.pattern_case == CASE_C && !i_cfg.paired_band) begin
                    cutoff = i_cfg.cutoff_c_unpaired;
                end
                // low band carriers only use the first two slots
                cand_ok = !(i_cfg.carrier_arfcn <= cutoff && i_slot > C_SLOT_W'(1))
                          && i_slot < C_SLOT_W'(4);
                idx0    = {3'b000, i_slot[1:0], 1'b0};
                if (i_cfg.pattern_case == CASE_B) begin
                    st0 = odd ? 4'd2 : 4'd4;
                    st1 = odd ? 4'd6 : 4'd8;
                end
            end
            default: begin
                cand_ok = 1'b0;
            end
        endcase
        b0 = cand_ok && i_cfg.burst_bitmap[6'd63 - idx0];
        b1 = cand_ok && i_cfg.burst_bitmap[6'd63 - (idx0 | 6'd1)];
        if (b0) begin
            n_pos.first_index = idx0;
            n_pos.first_start = st0;
            n_pos.first_stop  = st0 + 4'd4;
            if (b1) begin
                n_pos.second_index = idx0 | 6'd1;
                n_pos.second_start = st1;
                n_pos.second_stop  = st1 + 4'd4;
            end
        end else if (b1) begin
            n_pos.first_index = idx0 | 6'd1;
            n_pos.first_start = st1;
            n_pos.first_stop  = st1 + 4'd4;
        end
        n_pos.position_count = 2'(b0) + 2'(b1);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pos <= n_pos;
        end
    end

    assign o_valid = r_valid;
    assign o_pos   = r_pos;
endmodule

### sv/ssb_slot_position_selector.sv
// ssb slot position selector top level
// throughput: one word per cycle unless backpressured; six modulo stages of three
//   compare-subtract steps each, then one decode stage with output register
// each stage holds its word under backpressure and fills bubbles
// reset: synchronous active low, clears valid bits and loads register defaults
module ssb_slot_position_selector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ssb_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssb_pkg::C_CFG_W-1:0]     i_cfg_data,
    ssb_slot_if.sink                        i_slot,
    ssb_pos_if.source                       o_pos
);
    import ssb_pkg::*;

    t_ssb_cfg            r_cfg;
    logic [C_MOD_W-1:0]  w_modulus;
    logic                w_valid [C_MOD_STAGES+1];
    logic                w_ready [C_MOD_STAGES+1];
    logic [C_SLOT_W-1:0] w_rem   [C_MOD_STAGES+1];
    t_ssb_pos            w_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_case      <= CASE_A;
            r_cfg.paired_band       <= 1'b1;
            r_cfg.carrier_arfcn     <= '0;
            r_cfg.cutoff_abc        <= C_ARFCN_W'(600000);
            r_cfg.cutoff_c_unpaired <= C_ARFCN_W'(376000);
            r_cfg.burst_bitmap      <= {1'b1, 63'b0};
            r_cfg.period_ms         <= 8'd20;
            r_cfg.numerology        <= 2'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_PATTERN_CASE:  r_cfg.pattern_case      <= i_cfg_data[1:0];
                REG_PAIRED:        r_cfg.paired_band       <= i_cfg_data[0];
                REG_CARRIER_ARFCN: r_cfg.carrier_arfcn     <= i_cfg_data[C_ARFCN_W-1:0];
                REG_CUTOFF_ABC:    r_cfg.cutoff_abc        <= i_cfg_data[C_ARFCN_W-1:0];
                REG_CUTOFF_C:      r_cfg.cutoff_c_unpaired <= i_cfg_data[C_ARFCN_W-1:0];
                REG_BURST_BITMAP:  r_cfg.burst_bitmap      <= i_cfg_data;
                REG_PERIOD_MS:     r_cfg.period_ms         <= i_cfg_data[7:0];
                REG_NUMEROLOGY:    r_cfg.numerology        <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // slots per ssb period
    assign w_modulus = C_MOD_W'(r_cfg.period_ms) << r_cfg.numerology;

    assign w_valid[0]    = i_slot.valid;
    assign w_rem[0]      = i_slot.slot_number;
    assign i_slot.ready  = w_ready[0];

    for (genvar s = 0; s < C_MOD_STAGES; s++) begin : g_mod
        ssb_mod_stage #(
            .K_HI(C_STEPS * C_MOD_STAGES - 1 - C_STEPS * s)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_valid[s]),
            .o_ready   (w_ready[s]),
            .i_rem     (w_rem[s]),
            .i_modulus (w_modulus),
            .o_valid   (w_valid[s+1]),
            .i_ready   (w_ready[s+1]),
            .o_rem     (w_rem[s+1])
        );
    end

    ssb_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_valid[C_MOD_STAGES]),
        .o_ready (w_ready[C_MOD_STAGES]),
        .i_slot  (w_rem[C_MOD_STAGES]),
        .o_valid (o_pos.valid),
        .i_ready (o_pos.ready),
        .o_pos   (w_pos)
    );

    assign o_pos.position_count = w_pos.position_count;
    assign o_pos.first_index    = w_pos.first_index;
    assign o_pos.first_start    = w_pos.first_start;
    assign o_pos.first_stop     = w_pos.first_stop;
    assign o_pos.second_index   = w_pos.second_index;
    assign o_pos.second_start   = w_pos.second_start;
    assign o_pos.second_stop    = w_pos.second_stop;

`ifndef SYNTHESIS
    // a reset cycle leaves no result word behind
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pos.valid)
        else $error("result valid right after reset");

    // an input word can only enter if the first stage has room
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_slot.ready && !w_ready[1]) |-> !w_valid[1])
        else $error("first stage accepts while full and blocked");

    // an unfilled second position reads as zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pos.valid && o_pos.position_count != 2'd2) |->
        (o_pos.second_index == 6'd0 && o_pos.second_start == 4'd0
         && o_pos.second_stop == 4'd0))
        else $error("second position filled without a second block");

    // with both positions filled, each spans four symbols in rising index order
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pos.valid && o_pos.position_count == 2'd2) |->
        (o_pos.first_stop == o_pos.first_start + 4'd4
         && o_pos.second_stop == o_pos.second_start + 4'd4
         && o_pos.second_index == o_pos.first_index + 6'd1))
        else $error("position pair malformed");
`endif
endmodule

### test/tb_top.sv
// self-checking testbench for the ssb slot position selector
`timescale 1ns / 100ps

module tb_top;
    import ssb_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RAND_PHASES = 14;
    localparam int PHASE_WORDS = 125;
    localparam int unsigned SLOT_MAX = (1 << C_SLOT_W) - 1;
    localparam int unsigned STD_PERIODS [6] = '{5, 10, 20, 40, 80, 160};
    localparam int unsigned D_SLOT_PAIRS [16] = '{
        0, 1, 2, 3, 5, 6, 7, 8, 10, 11, 12, 13, 15, 16, 17, 18
    };

    class ssb_pos_scoreboard;
        t_ssb_cfg regs;
        t_ssb_pos pos_due [$];
        int       errors;

        function new();
            regs.pattern_case      = CASE_A;
            regs.paired_band       = 1'b1;
            regs.carrier_arfcn     = '0;
            regs.cutoff_abc        = 22'd600000;
            regs.cutoff_c_unpaired = 22'd376000;
            regs.burst_bitmap      = 64'h8000_0000_0000_0000;
            regs.period_ms         = 8'd20;
            regs.numerology        = 2'd0;
            errors                 = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [C_CFG_W-1:0] data);
            case (idx)
                REG_PATTERN_CASE:  regs.pattern_case      = data[1:0];
                REG_PAIRED:        regs.paired_band       = data[0];
                REG_CARRIER_ARFCN: regs.carrier_arfcn     = data[C_ARFCN_W-1:0];
                REG_CUTOFF_ABC:    regs.cutoff_abc        = data[C_ARFCN_W-1:0];
                REG_CUTOFF_C:      regs.cutoff_c_unpaired = data[C_ARFCN_W-1:0];
                REG_BURST_BITMAP:  regs.burst_bitmap      = data;
                REG_PERIOD_MS:     regs.period_ms         = data[7:0];
                REG_NUMEROLOGY:    regs.numerology        = data[1:0];
                default: ;
            endcase
        endfunction

        // fills the next free position if the block is enabled in the bitmap
        function void place(inout t_ssb_pos r, inout int cnt,
                            input int unsigned idx, input int unsigned start);
            if (!regs.burst_bitmap[63 - idx] || cnt >= 2) begin
                return;
            end
            if (cnt == 0) begin
                r.first_index  = idx[5:0];
                r.first_start  = start[3:0];
                r.first_stop   = 4'(start + 4);
            end else begin
                r.second_index = idx[5:0];
                r.second_start = start[3:0];
                r.second_stop  = 4'(start + 4);
            end
            cnt++;
        endfunction

        function t_ssb_pos locate_ssbs(logic [C_SLOT_W-1:0] slot_word);
            t_ssb_pos    r;
            int          cnt;
            int unsigned slot;
            int unsigned modulus;
            int unsigned cut;
            int unsigned odd;
            int unsigned first;
            r       = '0;
            cnt     = 0;
            slot    = 32'(slot_word);
            modulus = int'(regs.period_ms) << regs.numerology;
            if (modulus != 0) begin
                slot = slot % modulus;
            end
            odd = slot & 1;
            if (regs.pattern_case == CASE_D) begin
                if (slot < 40) begin
                    for (int k = 0; k < 16; k++) begin
                        if (D_SLOT_PAIRS[k] == slot / 2) begin
                            first = 4 * k + 2 * odd;
                            place(r, cnt, first, odd ? 2 : 4);
                            place(r, cnt, first + 1, odd ? 6 : 8);
                        end
                    end
                end
            end else begin
                cut = (regs.pattern_case == CASE_C && !regs.paired_band) ?
                      32'(regs.cutoff_c_unpaired) : 32'(regs.cutoff_abc);
                // at or below the cutoff only the first two slots carry blocks
                if (!(regs.carrier_arfcn <= cut && slot > 1) && slot < 4) begin
                    if (regs.pattern_case == CASE_B) begin
                        place(r, cnt, 2 * slot, odd ? 2 : 4);
                        place(r, cnt, 2 * slot + 1, odd ? 6 : 8);
                    end else begin
                        place(r, cnt, 2 * slot, 2);
                        place(r, cnt, 2 * slot + 1, 8);
                    end
                end
            end
            r.position_count = 2'(cnt);
            return r;
        endfunction

        function void note_slot(logic [C_SLOT_W-1:0] slot_word);
            pos_due.insert(pos_due.size(), locate_ssbs(slot_word));
        endfunction

        function void match(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_pos(t_ssb_pos got);
            t_ssb_pos want;
            if (pos_due.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected, expected none actual %h",
                         $time, got);
                return;
            end
            want = pos_due.pop_front();
            match("position_count", 32'(want.position_count), 32'(got.position_count));
            match("first_index", 32'(want.first_index), 32'(got.first_index));
            match("first_start", 32'(want.first_start), 32'(got.first_start));
            match("first_stop", 32'(want.first_stop), 32'(got.first_stop));
            match("second_index", 32'(want.second_index), 32'(got.second_index));
            match("second_start", 32'(want.second_start), 32'(got.second_start));
            match("second_stop", 32'(want.second_stop), 32'(got.second_stop));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [C_CFG_IDX_W-1:0] cfg_idx;
    logic [C_CFG_W-1:0]     cfg_data;
    int                     burst_left = 0;
    int                     quiet_cycles = 0;
    ssb_pos_scoreboard      sb = new();

    ssb_slot_if slot_if ();
    ssb_pos_if  pos_if ();

    ssb_slot_position_selector u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_slot     (slot_if),
        .o_pos      (pos_if)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver stalls in modes of random length
    initial begin
        int stall_mode;
        int stall_left;
        int stall_phase;
        stall_mode   = 0;
        stall_left   = 0;
        stall_phase  = 0;
        pos_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            stall_phase++;
            case (stall_mode)
                0: pos_if.ready = 1'b1;
                1: pos_if.ready = 1'($urandom_range(0, 1));
                2: pos_if.ready = (stall_phase % 4 == 0);
                default: pos_if.ready = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && pos_if.valid && pos_if.ready) begin
            sb.check_pos({pos_if.position_count, pos_if.first_index, pos_if.first_start,
                          pos_if.first_stop, pos_if.second_index, pos_if.second_start,
                          pos_if.second_stop});
        end
    end

    always @(posedge clk) begin
        if ((slot_if.valid && slot_if.ready) || (pos_if.valid && pos_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // lowers valid and holds off until every expected word has come back
    task automatic drain_results();
        @(negedge clk);
        slot_if.valid = 1'b0;
        while (sb.pos_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [C_CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        sb.write_reg(idx, data);
    endtask

    task automatic apply_cfg(t_ssb_cfg c);
        drain_results();
        write_reg(REG_PATTERN_CASE, 64'(c.pattern_case));
        write_reg(REG_PAIRED, 64'(c.paired_band));
        write_reg(REG_CARRIER_ARFCN, 64'(c.carrier_arfcn));
        write_reg(REG_CUTOFF_ABC, 64'(c.cutoff_abc));
        write_reg(REG_CUTOFF_C, 64'(c.cutoff_c_unpaired));
        write_reg(REG_BURST_BITMAP, c.burst_bitmap);
        write_reg(REG_PERIOD_MS, 64'(c.period_ms));
        write_reg(REG_NUMEROLOGY, 64'(c.numerology));
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_slot(logic [C_SLOT_W-1:0] s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                slot_if.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        slot_if.valid       = 1'b1;
        slot_if.slot_number = s;
        @(posedge clk);
        while (!slot_if.ready) begin
            @(posedge clk);
        end
        sb.note_slot(s);
    endtask

    function automatic t_ssb_cfg mk_cfg(t_pattern pat, logic paired, int unsigned arfcn,
                                        int unsigned cut_abc, int unsigned cut_c,
                                        logic [63:0] bitmap, int unsigned period,
                                        int unsigned num);
        t_ssb_cfg c;
        c.pattern_case      = pat;
        c.paired_band       = paired;
        c.carrier_arfcn     = C_ARFCN_W'(arfcn);
        c.cutoff_abc        = C_ARFCN_W'(cut_abc);
        c.cutoff_c_unpaired = C_ARFCN_W'(cut_c);
        c.burst_bitmap      = bitmap;
        c.period_ms         = 8'(period);
        c.numerology        = 2'(num);
        return c;
    endfunction

    task automatic run_list(t_ssb_cfg c, int n, int unsigned slots [8]);
        apply_cfg(c);
        for (int i = 0; i < n; i++) begin
            send_slot(C_SLOT_W'(slots[i]));
        end
    endtask

    function automatic logic [C_ARFCN_W-1:0] pick_arfcn();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return C_ARFCN_W'(3279165);
            2: return '1;
            default: return C_ARFCN_W'($urandom_range(0, 3279165));
        endcase
    endfunction

    function automatic t_ssb_cfg rand_cfg();
        t_ssb_cfg             c;
        logic [C_ARFCN_W-1:0] ref_cut;
        c.pattern_case      = 2'($urandom_range(0, 3));
        c.paired_band       = 1'($urandom_range(0, 1));
        c.cutoff_abc        = pick_arfcn();
        c.cutoff_c_unpaired = pick_arfcn();
        ref_cut = (c.pattern_case == CASE_C && !c.paired_band) ?
                  c.cutoff_c_unpaired : c.cutoff_abc;
        // keep the carrier close to its cutoff most of the time
        case ($urandom_range(0, 3))
            0: c.carrier_arfcn = ref_cut;
            1: c.carrier_arfcn = ref_cut + 1'b1;
            2: c.carrier_arfcn = ref_cut - 1'b1;
            default: c.carrier_arfcn = pick_arfcn();
        endcase
        case ($urandom_range(0, 5))
            0: c.burst_bitmap = '1;
            1: c.burst_bitmap = '0;
            2: c.burst_bitmap = 64'd1 << $urandom_range(0, 63);
            default: c.burst_bitmap = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 9))
            0: c.period_ms = 8'd0;
            1: c.period_ms = 8'd255;
            2: c.period_ms = 8'($urandom_range(1, 254));
            default: c.period_ms = 8'(STD_PERIODS[$urandom_range(0, 5)]);
        endcase
        c.numerology = 2'($urandom_range(0, 3));
        return c;
    endfunction

    // mostly slots that reduce to the first few of a period
    function automatic logic [C_SLOT_W-1:0] pick_slot();
        int unsigned modulus;
        int unsigned r;
        int unsigned kmax;
        if ($urandom_range(0, 3) == 0) begin
            return C_SLOT_W'($urandom_range(0, SLOT_MAX));
        end
        modulus = int'(sb.regs.period_ms) << sb.regs.numerology;
        r = (sb.regs.pattern_case == CASE_D) ? $urandom_range(0, 41) : $urandom_range(0, 5);
        if (modulus == 0) begin
            return C_SLOT_W'(r);
        end
        kmax = (SLOT_MAX - r) / modulus;
        return C_SLOT_W'(r + modulus * $urandom_range(0, kmax));
    endfunction

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = REG_PATTERN_CASE;
        cfg_data            = '0;
        slot_if.valid       = 1'b0;
        slot_if.slot_number = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // case a below and above the cutoff
        run_list(mk_cfg(CASE_A, 1'b1, 0, 600000, 376000, '1, 5, 0),
                 4, '{0, 1, 2, 3, 0, 0, 0, 0});
        run_list(mk_cfg(CASE_A, 1'b1, 3279165, 0, 0, '1, 10, 2),
                 4, '{2, 3, 4, 81919, 0, 0, 0, 0});
        // case b even and odd slots, alternating bitmap, longest period
        run_list(mk_cfg(CASE_B, 1'b1, 4194303, 3279165, 0, 64'hAAAA_AAAA_AAAA_AAAA, 160, 3),
                 4, '{0, 1, 3, 131071, 0, 0, 0, 0});
        // case c unpaired exactly at its cutoff, then paired just above
        run_list(mk_cfg(CASE_C, 1'b0, 376000, 4194303, 376000, '1, 20, 1),
                 2, '{1, 2, 0, 0, 0, 0, 0, 0});
        run_list(mk_cfg(CASE_C, 1'b1, 600001, 600000, 4194303, 64'h0F0F_0F0F_0F0F_0F0F, 40, 0),
                 2, '{3, 42, 0, 0, 0, 0, 0, 0});
        // case d with zero period, then an odd period and a one-bit bitmap
        run_list(mk_cfg(CASE_D, 1'b1, 0, 0, 0, '1, 0, 3),
                 7, '{0, 1, 7, 8, 37, 39, 40, 0});
        run_list(mk_cfg(CASE_D, 1'b0, 3279165, 0, 0, 64'd1, 255, 1),
                 2, '{547, 510, 0, 0, 0, 0, 0, 0});

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            apply_cfg(rand_cfg());
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if ($urandom_range(0, 199) == 0) begin
                    drain_results();
                end
                send_slot(pick_slot());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pos_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
sv/ssb_pkg.sv
sv/ssb_slot_if.sv
sv/ssb_pos_if.sv
sv/ssb_mod_stage.sv
sv/ssb_decode.sv
sv/ssb_slot_position_selector.sv
test/tb_top.sv
